[rtl/encoder_accel_bound_counter_unit_defines.svh]
// Assertion macros used by the checker file of the encoder counter.
// Depends on nothing; included by bare file name where assertions are written.
`ifndef ENCODER_ACCEL_BOUND_COUNTER_UNIT_DEFINES_SVH
`define ENCODER_ACCEL_BOUND_COUNTER_UNIT_DEFINES_SVH

// Assertion that is switched off while reset is high.
`define EABC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is checked during reset as well.
`define EABC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/eabc_pkg.sv]
// Package of the encoder acceleration and bound counter: codes, states and constants.
// Depends on nothing; used by the top level and by its checker.
package eabc_pkg;

   localparam int unsigned REQ_DATA_W = 72;
   localparam int unsigned RSP_DATA_W = 80;
   localparam int unsigned CSR_DATA_W = 32;

   // Dividend of the speed quotient and the reciprocal that replaces division by 100.
   localparam logic [9:0]  SPEED_NUM   = 10'd1000;
   localparam logic [27:0] RECIP_100   = 28'd85899346;
   localparam int unsigned RECIP_SHIFT = 33;

   typedef enum logic [1:0] {
      REQ_PULSE    = 2'd0,
      REQ_WR_POS   = 2'd1,
      REQ_WR_BOUND = 2'd2
   } eabc_req_type;

   typedef enum logic [2:0] {
      CSR_ACCEL_SCALE = 3'd0,
      CSR_STEP_CAP    = 3'd1,
      CSR_ACCEL_POS   = 3'd2,
      CSR_WRAP        = 3'd3,
      CSR_BIND_MODE   = 3'd4,
      CSR_BIND_GAIN   = 3'd5,
      CSR_BOUND_LOW   = 3'd6,
      CSR_BOUND_HIGH  = 3'd7
   } eabc_csr_type;

   typedef enum logic [1:0] {
      BIND_OFF = 2'd0,
      BIND_TRIM8 = 2'd1,
      BIND_TRIM16 = 2'd2
   } eabc_bind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_SPEED,
      ST_MUL_SCALE,
      ST_MUL_RECIP,
      ST_STEP,
      ST_MUL_GAIN,
      ST_TRIM,
      ST_BOUND,
      ST_DONE
   } eabc_state_type;

endpackage

[rtl/encoder_accel_bound_counter_unit.sv]
// Encoder pulse counter with speed-based acceleration and a bounded companion value.
// An encoder pulse beat runs from acceptance to result through the bit-serial speed
// divider, speed capture, speed times scale and division by 100 as a reciprocal product
// on the shared multiplier, the step, step times gain as the third multiplier pass, trim,
// bound update and result load. With binding off the bound update is skipped. A position
// or bound write goes from acceptance straight to the result load. The block takes one
// beat at a time and is ready again in the cycle after the result load; it accepts the
// next beat while a finished result still waits in the output register, and a result is
// loaded only when that register is free or is being emptied as the result is loaded.
// Depends on eabc_pkg.
module encoder_accel_bound_counter_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // counting_down [0], time_ms [32:1], write_value [64:33], zero fill above.
   input  logic [eabc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_type [1:0].
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // position [31:0], speed [41:32], bound_value [73:42], turning_up [74], zero fill above.
   output logic [eabc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [2:0]                          csr_index,
   input  logic [eabc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import eabc_pkg::*;

   eabc_state_type state_ff, state_in;

   logic [15:0]        scale_ff;
   logic [9:0]         cap_ff;
   logic               accel_pos_ff;
   logic               wrap_ff;
   logic [1:0]         bind_mode_ff;
   logic signed [15:0] gain_ff;
   logic signed [31:0] low_ff;
   logic signed [31:0] high_ff;

   logic [31:0]        position_ff, position_in;
   logic [31:0]        last_time_ff, last_time_in;
   logic [31:0]        bound_ff, bound_in;
   logic               last_down_ff, last_down_in;
   logic [9:0]         last_speed_ff, last_speed_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               down_ff, down_in;
   logic [31:0]        time_ff, time_in;
   logic [31:0]        elapsed_ff, elapsed_in;
   logic [9:0]         rem_ff, rem_in;
   logic [9:0]         quo_ff, quo_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic signed [55:0] prod_ff, prod_in;
   logic signed [20:0] step_ff, step_in;
   logic signed [16:0] inc_ff, inc_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic signed [27:0] mul_a;
   logic signed [27:0] mul_b;
   logic signed [55:0] mul_p;

   logic [10:0]        div_r;
   logic [10:0]        div_diff;
   logic               div_ge;
   logic [19:0]        quot100;
   logic [19:0]        step_mag;
   logic signed [33:0] cur_w;
   logic signed [33:0] inc_w;
   logic signed [33:0] lim_w;
   logic signed [33:0] sum_w;

   assign mul_p = mul_a * mul_b;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign div_r    = {rem_ff, SPEED_NUM[cnt_ff]};
   assign div_ge   = ({21'd0, div_r} >= elapsed_ff);
   assign div_diff = div_r - elapsed_ff[10:0];
   assign quot100  = prod_ff[RECIP_SHIFT+19:RECIP_SHIFT];

   always_comb begin
      if (scale_ff == 16'd0 || quot100 == 20'd0) begin
         step_mag = 20'd1;
      end else if (cap_ff != 10'd0 && quot100 > {10'd0, cap_ff}) begin
         step_mag = {10'd0, cap_ff};
      end else begin
         step_mag = quot100;
      end
   end

   assign cur_w = {{2{bound_ff[31]}}, bound_ff};
   assign inc_w = {{17{inc_ff[16]}}, inc_ff};
   assign lim_w = (inc_ff > 17'sd0) ? ({{2{high_ff[31]}}, high_ff} - inc_w)
                                    : ({{2{low_ff[31]}}, low_ff} - inc_w);
   assign sum_w = cur_w + inc_w;

   always_comb begin
      state_in      = state_ff;
      position_in   = position_ff;
      last_time_in  = last_time_ff;
      bound_in      = bound_ff;
      last_down_in  = last_down_ff;
      last_speed_in = last_speed_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      down_in       = down_ff;
      time_in       = time_ff;
      elapsed_in    = elapsed_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      prod_in       = prod_ff;
      step_in       = step_ff;
      inc_in        = inc_ff;
      rsp_data_in   = rsp_data_ff;
      mul_a         = {18'd0, last_speed_ff};
      mul_b         = {12'd0, scale_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               down_in    = req_tdata[0];
               time_in    = req_tdata[32:1];
               elapsed_in = req_tdata[32:1] - last_time_ff;
               rem_in     = 10'd0;
               quo_in     = 10'd0;
               cnt_in     = 4'd9;
               state_in   = ST_DONE;
               case (req_tuser)
                  REQ_PULSE: begin
                     state_in = ST_DIV;
                  end
                  REQ_WR_POS: begin
                     position_in = req_tdata[64:33];
                  end
                  REQ_WR_BOUND: begin
                     bound_in = req_tdata[64:33];
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            rem_in = div_ge ? div_diff[9:0] : div_r[9:0];
            quo_in = {quo_ff[8:0], div_ge};
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               state_in = ST_SPEED;
            end
         end
         ST_SPEED: begin
            last_speed_in = (elapsed_ff == 32'd0) ? SPEED_NUM : quo_ff;
            last_time_in  = time_ff;
            last_down_in  = down_ff;
            state_in      = ST_MUL_SCALE;
         end
         ST_MUL_SCALE: begin
            prod_in  = mul_p;
            state_in = ST_MUL_RECIP;
         end
         ST_MUL_RECIP: begin
            mul_a    = {2'd0, prod_ff[25:0]};
            mul_b    = RECIP_100;
            prod_in  = mul_p;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            step_in = down_ff ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
            if (accel_pos_ff) begin
               position_in = down_ff ? position_ff - {12'd0, step_mag}
                                     : position_ff + {12'd0, step_mag};
            end else begin
               position_in = down_ff ? position_ff - 32'd1 : position_ff + 32'd1;
            end
            state_in = ST_MUL_GAIN;
         end
         ST_MUL_GAIN: begin
            mul_a    = {{7{step_ff[20]}}, step_ff};
            mul_b    = {{12{gain_ff[15]}}, gain_ff};
            prod_in  = mul_p;
            state_in = ST_TRIM;
         end
         ST_TRIM: begin
            state_in = ST_BOUND;
            case (bind_mode_ff)
               BIND_TRIM8: begin
                  if (prod_ff > 56'sd127) begin
                     inc_in = 17'sd127;
                  end else if (prod_ff < -56'sd128) begin
                     inc_in = -17'sd128;
                  end else begin
                     inc_in = prod_ff[16:0];
                  end
               end
               BIND_TRIM16: begin
                  if (prod_ff > 56'sd32767) begin
                     inc_in = 17'sd32767;
                  end else if (prod_ff < -56'sd32768) begin
                     inc_in = -17'sd32768;
                  end else begin
                     inc_in = prod_ff[16:0];
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_BOUND: begin
            if (inc_ff > 17'sd0) begin
               if (cur_w < lim_w) begin
                  bound_in = sum_w[31:0];
               end else begin
                  bound_in = wrap_ff ? low_ff : high_ff;
               end
            end else begin
               if (cur_w > lim_w) begin
                  bound_in = sum_w[31:0];
               end else begin
                  bound_in = wrap_ff ? high_ff : low_ff;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {5'd0, ~last_down_ff, bound_ff, last_speed_ff, position_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         position_ff   <= 32'd0;
         last_time_ff  <= 32'd0;
         bound_ff      <= 32'd0;
         last_down_ff  <= 1'b0;
         last_speed_ff <= 10'd0;
         cnt_ff        <= 4'd0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         position_ff   <= position_in;
         last_time_ff  <= last_time_in;
         bound_ff      <= bound_in;
         last_down_ff  <= last_down_in;
         last_speed_ff <= last_speed_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= 16'd0;
         cap_ff       <= 10'd1;
         accel_pos_ff <= 1'b0;
         wrap_ff      <= 1'b0;
         bind_mode_ff <= 2'd0;
         gain_ff      <= 16'sd0;
         low_ff       <= 32'sd0;
         high_ff      <= 32'sd0;
      end else if (csr_we) begin
         case (eabc_csr_type'(csr_index))
            CSR_ACCEL_SCALE: scale_ff     <= csr_wdata[15:0];
            CSR_STEP_CAP:    cap_ff       <= csr_wdata[9:0];
            CSR_ACCEL_POS:   accel_pos_ff <= csr_wdata[0];
            CSR_WRAP:        wrap_ff      <= csr_wdata[0];
            CSR_BIND_MODE:   bind_mode_ff <= csr_wdata[1:0];
            CSR_BIND_GAIN:   gain_ff      <= csr_wdata[15:0];
            CSR_BOUND_LOW:   low_ff       <= csr_wdata;
            CSR_BOUND_HIGH:  high_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      down_ff     <= down_in;
      time_ff     <= time_in;
      elapsed_ff  <= elapsed_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      prod_ff     <= prod_in;
      step_ff     <= step_in;
      inc_ff      <= inc_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[rtl/eabc_checker.sv]
// Port-level checker for the encoder counter top level, attached by a bind statement.
// Depends on eabc_pkg and the assertion macros in the defines header.
`include "encoder_accel_bound_counter_unit_defines.svh"

module eabc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [eabc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import eabc_pkg::*;

   `EABC_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_tvalid, "result valid after reset")
   `EABC_ASSERT(a_busy_after_accept, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "input ready right after an accepted beat")
   `EABC_ASSERT(a_speed_range, clock, reset, rsp_tvalid |-> (rsp_tdata[41:32] <= SPEED_NUM), "speed above its maximum")
   `EABC_ASSERT(a_rsp_holds, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid, "result beat dropped while stalled")

endmodule

bind encoder_accel_bound_counter_unit eabc_checker u_eabc_checker (.*);

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench of encoder_accel_bound_counter_unit: directed beats, then random beats.
// Beats are checked for position, speed, bound value and direction by a predictor or fixed values.
// Depends on eabc_pkg and the RTL of the counter.
module testbench;
   import eabc_pkg::*;

   localparam logic [1:0] REQ_IGNORED  = 2'd3;
   localparam logic [1:0] BIND_IGNORED = 2'd3;
   localparam int RANDOM_BEATS = 450;
   localparam int HOLD_AT      = 60;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 24;

   typedef struct {
      logic [31:0] position;
      logic [9:0]  speed;
      logic [31:0] bound_value;
      logic        turning_up;
   } count_result_type;

   typedef struct {
      bit               is_reg;
      eabc_csr_type     reg_idx;
      logic [31:0]      reg_val;
      logic [1:0]       kind;
      logic             down;
      logic [31:0]      ms;
      logic [31:0]      wval;
      bit               known;
      count_result_type want;
   } plan_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Register copies kept by the predictor.
   logic [15:0]        set_scale = 16'd0;
   logic [9:0]         set_cap = 10'd1;
   logic               set_accel_pos = 1'b0;
   logic               set_wrap = 1'b0;
   logic [1:0]         set_bind = BIND_OFF;
   logic signed [15:0] set_gain = 16'sd0;
   logic signed [31:0] set_low = 32'sd0;
   logic signed [31:0] set_high = 32'sd0;

   // Counter state kept by the predictor.
   logic [31:0]        cnt_position = '0;
   logic [31:0]        cnt_last_ms = '0;
   logic signed [31:0] cnt_bound = '0;
   logic               cnt_down = 1'b0;
   logic [9:0]         cnt_speed = '0;

   count_result_type awaited_counts[$];
   plan_row_type     plan[$];
   int idle_mode = 0;
   int failures = 0;
   int beats_sent = 0;
   int pulses_sent = 0;
   int settings_used = 0;
   int results_checked = 0;
   int rsp_beats_seen = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   encoder_accel_bound_counter_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic count_result_type advance_counter(logic [1:0] kind, logic down,
                                                        logic [31:0] ms, logic [31:0] wval);
      logic [31:0] elapsed;
      logic [31:0] quotient;
      logic [9:0]  spd;
      longint step, inc, cur, lo, hi, lim_lo, lim_hi;
      count_result_type r;
      case (kind)
         REQ_PULSE: begin
            elapsed = ms - cnt_last_ms;
            quotient = (elapsed == 0) ? 32'd1000 : 32'd1000 / elapsed;
            spd = quotient[9:0];
            step = 1;
            if (set_scale != 0) begin
               step = (longint'(spd) * longint'(set_scale)) / 100;
               if (step == 0)
                  step = 1;
               else if (set_cap != 0 && step > longint'(set_cap))
                  step = longint'(set_cap);
            end
            if (down)
               step = -step;
            if (set_accel_pos)
               cnt_position = cnt_position + step[31:0];
            else
               cnt_position = down ? cnt_position - 32'd1 : cnt_position + 32'd1;
            if (set_bind == BIND_TRIM8 || set_bind == BIND_TRIM16) begin
               inc = step * longint'(set_gain);
               cur = longint'(cnt_bound);
               lo = longint'(set_low);
               hi = longint'(set_high);
               if (set_bind == BIND_TRIM8) begin
                  lim_lo = -128;
                  lim_hi = 127;
               end else begin
                  lim_lo = -32768;
                  lim_hi = 32767;
               end
               inc = (inc < lim_lo) ? lim_lo : ((inc > lim_hi) ? lim_hi : inc);
               if (inc > 0) begin
                  if (cur < hi - inc)
                     cur = cur + inc;
                  else
                     cur = set_wrap ? lo : hi;
               end else begin
                  if (cur > lo - inc)
                     cur = cur + inc;
                  else
                     cur = set_wrap ? hi : lo;
               end
               cnt_bound = cur[31:0];
            end
            cnt_down = down;
            cnt_speed = spd;
            cnt_last_ms = ms;
         end
         REQ_WR_POS: cnt_position = wval;
         REQ_WR_BOUND: cnt_bound = wval;
         default: ;
      endcase
      r.position = cnt_position;
      r.speed = cnt_speed;
      r.bound_value = cnt_bound;
      r.turning_up = ~cnt_down;
      return r;
   endfunction

   function automatic plan_row_type reg_row(eabc_csr_type idx, logic [31:0] val);
      plan_row_type row;
      row = '{reg_idx: CSR_ACCEL_SCALE, default: '0};
      row.is_reg = 1'b1;
      row.reg_idx = idx;
      row.reg_val = val;
      return row;
   endfunction

   function automatic plan_row_type beat_row(logic [1:0] kind, logic down, logic [31:0] ms,
                                             logic [31:0] wval);
      plan_row_type row;
      row = '{reg_idx: CSR_ACCEL_SCALE, default: '0};
      row.kind = kind;
      row.down = down;
      row.ms = ms;
      row.wval = wval;
      return row;
   endfunction

   function automatic plan_row_type known_row(logic [1:0] kind, logic down, logic [31:0] ms,
                                              logic [31:0] wval, logic [31:0] pos,
                                              logic [9:0] spd, logic [31:0] bnd, logic up);
      plan_row_type row;
      row = beat_row(kind, down, ms, wval);
      row.known = 1'b1;
      row.want = '{pos, spd, bnd, up};
      return row;
   endfunction

   task automatic write_reg(eabc_csr_type idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_ACCEL_SCALE: set_scale = val[15:0];
         CSR_STEP_CAP:    set_cap = val[9:0];
         CSR_ACCEL_POS:   set_accel_pos = val[0];
         CSR_WRAP:        set_wrap = val[0];
         CSR_BIND_MODE:   set_bind = val[1:0];
         CSR_BIND_GAIN:   set_gain = val[15:0];
         CSR_BOUND_LOW:   set_low = val;
         CSR_BOUND_HIGH:  set_high = val;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do
         @(posedge clock);
      while (awaited_counts.size() != 0);
   endtask

   task automatic send_beat(logic [1:0] kind, logic down, logic [31:0] ms, logic [31:0] wval,
                            bit known, count_result_type typed);
      count_result_type want;
      int idle_pct;
      if (csr_we)
         csr_we <= 1'b0;
      idle_pct = (idle_mode == 0) ? 22 : ((idle_mode == 1) ? 84 : 0);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {7'd0, wval, ms, down};
      do
         @(posedge clock);
      while (!req_tready);
      want = advance_counter(kind, down, ms, wval);
      if (known)
         want = typed;
      awaited_counts.push_back(want);
      beats_sent++;
      if (kind == REQ_PULSE)
         pulses_sent++;
   endtask

   task automatic new_settings(int phase);
      logic [31:0] v [8];
      wait_drained();
      if (phase == 0) begin
         v = '{32'd65535, 32'd1000, 32'd1, 32'd1, 32'(BIND_TRIM16), 32'h0000_7FFF,
               32'h8000_0000, 32'h7FFF_FFFF};
      end else if (phase == 1) begin
         v = '{32'd0, 32'd0, 32'd0, 32'd0, 32'(BIND_TRIM8), 32'hFFFF_8000, 32'd0, 32'd0};
      end else begin
         case ($urandom_range(0, 5))
            0: v[0] = 32'd0;
            1: v[0] = 32'd1;
            2: v[0] = 32'd100;
            3: v[0] = 32'd65535;
            default: v[0] = $urandom_range(1, 400);
         endcase
         case ($urandom_range(0, 6))
            0: v[1] = 32'd0;
            1: v[1] = 32'd1;
            2: v[1] = 32'd1000;
            3: v[1] = 32'd1023;
            default: v[1] = $urandom_range(1, 1000);
         endcase
         v[2] = $urandom_range(0, 1);
         v[3] = $urandom_range(0, 1);
         case ($urandom_range(0, 5))
            0: v[4] = 32'(BIND_OFF);
            1: v[4] = 32'(BIND_IGNORED);
            2, 3: v[4] = 32'(BIND_TRIM8);
            default: v[4] = 32'(BIND_TRIM16);
         endcase
         case ($urandom_range(0, 7))
            0: v[5] = 32'd0;
            1: v[5] = 32'd1;
            2: v[5] = 32'hFFFF_FFFF;
            3: v[5] = 32'h0000_7FFF;
            4: v[5] = 32'hFFFF_8000;
            5, 6: v[5] = $urandom_range(0, 600) - 32'd300;
            default: v[5] = $urandom;
         endcase
         case ($urandom_range(0, 7))
            0: begin
               v[6] = 32'h8000_0000;
               v[7] = 32'h7FFF_FFFF;
            end
            1: begin
               v[6] = $urandom_range(0, 500);
               v[7] = 32'd0 - $urandom_range(0, 500);
            end
            2: begin
               v[6] = $urandom;
               v[7] = $urandom;
            end
            default: begin
               v[6] = 32'd0 - $urandom_range(0, 3000);
               v[7] = $urandom_range(0, 3000);
            end
         endcase
      end
      write_reg(CSR_ACCEL_SCALE, v[0]);
      write_reg(CSR_STEP_CAP, v[1]);
      write_reg(CSR_ACCEL_POS, v[2]);
      write_reg(CSR_WRAP, v[3]);
      write_reg(CSR_BIND_MODE, v[4]);
      write_reg(CSR_BIND_GAIN, v[5]);
      write_reg(CSR_BOUND_LOW, v[6]);
      write_reg(CSR_BOUND_HIGH, v[7]);
      settings_used++;
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         rsp_beats_seen <= rsp_beats_seen + 1;
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && rsp_beats_seen == HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(0, 99) >= ((idle_mode == 0) ? 84 :
                                                 ((idle_mode == 1) ? 22 : 0));
      end
   end

   always @(posedge clock) begin
      count_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_counts.size() == 0) begin
            $error("result beat arrived with no expectation pending");
            failures++;
         end else begin
            want = awaited_counts.pop_front();
            check_field("position", want.position, rsp_tdata[31:0]);
            check_field("speed", 32'(want.speed), 32'(rsp_tdata[41:32]));
            check_field("bound_value", want.bound_value, rsp_tdata[73:42]);
            check_field("turning_up", 32'(want.turning_up), 32'(rsp_tdata[74]));
            results_checked++;
         end
      end
   end

   initial begin
      logic [1:0] kind;
      logic down;
      logic [31:0] ms, wval;
      int sent, phase, len, sel;
      bit last_was_reg;
      count_result_type none;

      none = '{default: '0};
      plan.push_back(known_row(REQ_PULSE, 1'b0, 32'd0, 32'd0, 32'd1, 10'd1000, 32'd0, 1'b1));
      plan.push_back(known_row(REQ_PULSE, 1'b1, 32'd0, 32'd0, 32'd0, 10'd1000, 32'd0, 1'b0));
      plan.push_back(known_row(REQ_WR_POS, 1'b0, 32'd0, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 10'd1000, 32'd0, 1'b0));
      plan.push_back(known_row(REQ_PULSE, 1'b0, 32'd1000, 32'd0,
                               32'h8000_0000, 10'd1, 32'd0, 1'b1));
      plan.push_back(known_row(REQ_WR_BOUND, 1'b0, 32'd0, 32'h8000_0000,
                               32'h8000_0000, 10'd1, 32'h8000_0000, 1'b1));
      plan.push_back(known_row(REQ_IGNORED, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'h8000_0000, 10'd1, 32'h8000_0000, 1'b1));
      plan.push_back(known_row(REQ_PULSE, 1'b1, 32'hFFFF_FFFF, 32'd0,
                               32'h7FFF_FFFF, 10'd0, 32'h8000_0000, 1'b0));
      // Uncapped step with the largest gain, then saturation at the upper limit.
      plan.push_back(reg_row(CSR_ACCEL_SCALE, 32'd65535));
      plan.push_back(reg_row(CSR_STEP_CAP, 32'd0));
      plan.push_back(reg_row(CSR_ACCEL_POS, 32'd1));
      plan.push_back(reg_row(CSR_WRAP, 32'd0));
      plan.push_back(reg_row(CSR_BIND_MODE, 32'(BIND_TRIM16)));
      plan.push_back(reg_row(CSR_BIND_GAIN, 32'h0000_7FFF));
      plan.push_back(reg_row(CSR_BOUND_LOW, 32'd0 - 32'd100000));
      plan.push_back(reg_row(CSR_BOUND_HIGH, 32'd100000));
      plan.push_back(beat_row(REQ_WR_BOUND, 1'b0, 32'd0, 32'd0));
      plan.push_back(beat_row(REQ_PULSE, 1'b0, 32'hFFFF_FFFF, 32'd0));
      plan.push_back(beat_row(REQ_PULSE, 1'b1, 32'hFFFF_FFFF, 32'd0));
      repeat (4)
         plan.push_back(beat_row(REQ_PULSE, 1'b0, 32'hFFFF_FFFF, 32'd0));
      // Eight-bit trim with the most negative gain, wrapping at both full-range limits.
      plan.push_back(reg_row(CSR_STEP_CAP, 32'd1000));
      plan.push_back(reg_row(CSR_WRAP, 32'd1));
      plan.push_back(reg_row(CSR_BIND_MODE, 32'(BIND_TRIM8)));
      plan.push_back(reg_row(CSR_BIND_GAIN, 32'hFFFF_8000));
      plan.push_back(reg_row(CSR_BOUND_LOW, 32'h8000_0000));
      plan.push_back(reg_row(CSR_BOUND_HIGH, 32'h7FFF_FFFF));
      plan.push_back(beat_row(REQ_WR_BOUND, 1'b0, 32'd0, 32'h7FFF_FFF0));
      plan.push_back(beat_row(REQ_PULSE, 1'b1, 32'hFFFF_FFFF, 32'd0));
      plan.push_back(beat_row(REQ_PULSE, 1'b0, 32'hFFFF_FFFF, 32'd0));
      // Small scale rounds to a step of one; the unused bind mode leaves the bound alone.
      plan.push_back(reg_row(CSR_ACCEL_SCALE, 32'd1));
      plan.push_back(reg_row(CSR_BIND_MODE, 32'(BIND_IGNORED)));
      plan.push_back(reg_row(CSR_ACCEL_POS, 32'd0));
      plan.push_back(beat_row(REQ_PULSE, 1'b0, 32'd31, 32'd0));
      plan.push_back(beat_row(REQ_PULSE, 1'b1, 32'd32, 32'd0));
      plan.push_back(beat_row(REQ_WR_POS, 1'b1, 32'd0, 32'h8000_0000));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      last_was_reg = 1'b0;
      foreach (plan[i]) begin
         if (plan[i].is_reg) begin
            if (!last_was_reg)
               wait_drained();
            write_reg(plan[i].reg_idx, plan[i].reg_val);
            last_was_reg = 1'b1;
         end else begin
            if (last_was_reg)
               settings_used++;
            send_beat(plan[i].kind, plan[i].down, plan[i].ms, plan[i].wval,
                      plan[i].known, plan[i].known ? plan[i].want : none);
            last_was_reg = 1'b0;
         end
      end

      sent = 0;
      phase = 0;
      while (sent < RANDOM_BEATS) begin
         new_settings(phase);
         phase++;
         len = $urandom_range(10, 40);
         for (int k = 0; k < len && sent < RANDOM_BEATS; k++) begin
            idle_mode = (sent < RANDOM_BEATS / 3) ? 0 : ((sent < 2 * RANDOM_BEATS / 3) ? 1 : 2);
            if (sent == RANDOM_BEATS / 2)
               wait_drained();
            sel = $urandom_range(0, 99);
            kind = (sel < 72) ? REQ_PULSE : ((sel < 84) ? REQ_WR_POS :
                   ((sel < 95) ? REQ_WR_BOUND : REQ_IGNORED));
            down = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
               0: ms = cnt_last_ms;
               1, 2, 3: ms = cnt_last_ms + $urandom_range(1, 10);
               4, 5, 6, 7: ms = cnt_last_ms + $urandom_range(11, 1200);
               8: ms = cnt_last_ms + $urandom_range(1001, 100000);
               default: ms = $urandom;
            endcase
            case ($urandom_range(0, 9))
               0: wval = 32'h8000_0000;
               1: wval = 32'h7FFF_FFFF;
               2, 3, 4: wval = $urandom;
               default: wval = $urandom_range(0, 6000) - 32'd3000;
            endcase
            send_beat(kind, down, ms, wval, 1'b0, none);
            sent++;
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Checked %0d result beats for %0d request beats (%0d encoder pulses).",
               results_checked, beats_sent, pulses_sent);
      $display("Used %0d register settings, three idle patterns and one long result hold-off.",
               settings_used);
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
